[src/ngfc_pkg.sv]
// Shared types and constants for the n-gram frequency counter.
`default_nettype none
package ngfc_pkg;
  localparam int TABLE_ENTRIES = 1024;
  localparam int COUNT_WIDTH   = 32;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int USED_W        = IDX_W + 1;
  localparam logic KIND_TEXT   = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;
  localparam logic [0:0] REG_NGRAM_LENGTH = 1'b0;

  typedef struct packed {
    logic       kind;
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [31:0] gram;
    logic [31:0] gram_count;
    logic        dropped;
    logic        last_gram;
  } out_item_t;

  // Classified job passed from front to back
  typedef struct packed {
    logic        clear;
    logic [31:0] gram;
    logic        last;
  } job_t;
endpackage
`default_nettype wire

[src/ngram_frequency_counter.sv]
// Top level of the n-gram frequency counter.
//  channel  | handshake               | payload
//  input    | start / busy            | in_item (kind, text_byte, end_of_text)
//  result   | out_valid strobe        | out_item (gram, gram_count, dropped, last_gram)
//  config   | APB psel/penable/pwrite | ngram_length at address 0
// A gram is looked up entry by entry from entry 0 through the registered table read
// (S_READ, then S_CMP) until it matches; a new gram scans all used entries.
// Clear resets the fill count. Reset is synchronous, active low.
// busy rises while the two-entry job queue is full; results cannot be stalled.
`default_nettype none
module ngram_frequency_counter (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire ngfc_pkg::in_item_t  in_item,
  output logic                     out_valid,
  output ngfc_pkg::out_item_t      out_item,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [0:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  logic [2:0] len_r;
  logic take, jv, qv, qfull, bready;
  ngfc_pkg::job_t fj, qj;

  assign pready = 1'b1;
  assign prdata = (paddr == ngfc_pkg::REG_NGRAM_LENGTH) ? {29'd0, len_r} : 32'd0;

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) len_r <= 3'd1;
    else if (psel && penable && pwrite && paddr == ngfc_pkg::REG_NGRAM_LENGTH)
      len_r <= pwdata[2:0];
  end

  assign busy = qfull;
  assign take = start && !busy;

  ngfc_front u_front (.clk, .rst_n, .take, .item(in_item), .ngram_length(len_r),
                      .job_valid(jv), .job(fj));
  ngfc_queue u_queue (.clk, .rst_n, .push(jv), .push_job(fj), .pop(qv && bready),
                      .nonempty(qv), .full(qfull), .head(qj));
  ngfc_back u_back (.clk, .rst_n, .job_valid(qv), .job(qj), .job_ready(bready),
                    .out_valid, .out_item);
endmodule
`default_nettype wire

[src/ngfc_front.sv]
// Front end: window tracking and gram classification.
`default_nettype none
module ngfc_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire ngfc_pkg::in_item_t item,
  input  wire logic [2:0]        ngram_length,
  output logic                   job_valid,
  output ngfc_pkg::job_t         job
);
  logic [23:0] window_r;
  logic [1:0]  fill_r;
  logic [2:0]  n;
  logic [31:0] wide;

  // Clamp length to 1..4
  always_comb begin
    if (ngram_length == 3'd0) n = 3'd1;
    else if (ngram_length > 3'd4) n = 3'd4;
    else n = ngram_length;
  end

  assign wide = {window_r, item.text_byte};

  // Classify the item
  always_comb begin
    job.clear = (item.kind == ngfc_pkg::KIND_CLEAR);
    job.last  = item.end_of_text;
    case (n)
      3'd1: job.gram = {24'd0, wide[7:0]};
      3'd2: job.gram = {16'd0, wide[15:0]};
      3'd3: job.gram = {8'd0, wide[23:0]};
      default: job.gram = wide;
    endcase
    job_valid = take && (job.clear || ({1'b0, fill_r} + 3'd1 >= n));
  end

  // Advance the window, or empty it on a clear or end of text
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      fill_r   <= '0;
    end else if (take) begin
      if (item.kind == ngfc_pkg::KIND_CLEAR || item.end_of_text) begin
        window_r <= '0;
        fill_r   <= '0;
      end else begin
        window_r <= wide[23:0];
        if (fill_r != 2'd3) fill_r <= fill_r + 2'd1;
      end
    end
  end
endmodule
`default_nettype wire

[src/ngfc_back.sv]
// Back end: linear table search, insert or increment, result strobe.
`default_nettype none
module ngfc_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               job_valid,
  input  wire ngfc_pkg::job_t     job,
  output logic                    job_ready,
  output logic                    out_valid,
  output ngfc_pkg::out_item_t     out_item
);
  localparam logic [2:0] S_IDLE = 3'd0, S_READ = 3'd1, S_CMP = 3'd2,
                         S_WRITE = 3'd3, S_CLEAR = 3'd4;
  localparam logic [ngfc_pkg::COUNT_WIDTH-1:0] CMAX = '1;

  logic [31:0] key_mem [ngfc_pkg::TABLE_ENTRIES];
  logic [ngfc_pkg::COUNT_WIDTH-1:0] cnt_mem [ngfc_pkg::TABLE_ENTRIES];

  logic [2:0] state_r;
  logic [ngfc_pkg::USED_W-1:0] used_r, idx_r;
  logic [31:0] gram_r, rkey_r;
  logic        last_r;
  logic [ngfc_pkg::COUNT_WIDTH-1:0] rcnt_r, wcnt_r;
  logic        wen_r;
  logic [ngfc_pkg::IDX_W-1:0] waddr_r;
  logic [31:0] wkey_r;

  assign job_ready = (state_r == S_IDLE);

  // Table memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wen_r) begin
      key_mem[waddr_r] <= wkey_r;
      cnt_mem[waddr_r] <= wcnt_r;
    end
    rkey_r <= key_mem[idx_r[ngfc_pkg::IDX_W-1:0]];
    rcnt_r <= cnt_mem[idx_r[ngfc_pkg::IDX_W-1:0]];
  end

  // Sequencer: scan entries 0..used-1 until a match
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      used_r    <= '0;
      idx_r     <= '0;
      out_valid <= 1'b0;
      wen_r     <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      wen_r     <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            gram_r <= job.gram;
            last_r <= job.last;
            idx_r  <= '0;
            if (job.clear) state_r <= S_CLEAR;
            else state_r <= S_READ;
          end
        end
        S_CLEAR: begin
          used_r  <= '0;
          state_r <= S_IDLE;
        end
        S_READ: begin
          // read address settles; data lands next edge
          if (idx_r == used_r) state_r <= S_WRITE;
          else state_r <= S_CMP;
        end
        S_CMP: begin
          if (rkey_r == gram_r) begin
            wen_r   <= 1'b1;
            waddr_r <= idx_r[ngfc_pkg::IDX_W-1:0];
            wkey_r  <= gram_r;
            wcnt_r  <= (rcnt_r == CMAX) ? rcnt_r : rcnt_r + 1'b1;
            out_valid <= 1'b1;
            out_item.gram       <= gram_r;
            out_item.gram_count <= 32'((rcnt_r == CMAX) ? rcnt_r : rcnt_r + 1'b1);
            out_item.dropped    <= 1'b0;
            out_item.last_gram  <= last_r;
            state_r <= S_IDLE;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_READ;
          end
        end
        S_WRITE: begin
          out_valid <= 1'b1;
          out_item.gram      <= gram_r;
          out_item.last_gram <= last_r;
          if (used_r == ngfc_pkg::USED_W'(ngfc_pkg::TABLE_ENTRIES)) begin
            out_item.gram_count <= '0;
            out_item.dropped    <= 1'b1;
          end else begin
            wen_r   <= 1'b1;
            waddr_r <= used_r[ngfc_pkg::IDX_W-1:0];
            wkey_r  <= gram_r;
            wcnt_r  <= ngfc_pkg::COUNT_WIDTH'(1);
            used_r  <= used_r + 1'b1;
            out_item.gram_count <= 32'd1;
            out_item.dropped    <= 1'b0;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Fill count, scan index and result strobe stay in bounds
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= ngfc_pkg::USED_W'(ngfc_pkg::TABLE_ENTRIES)) else $error("used overflow");
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= used_r) else $error("scan past fill");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_IDLE) else $error("result while busy");
endmodule
`default_nettype wire

[src/ngfc_queue.sv]
// Two-entry job queue between front and back.
`default_nettype none
module ngfc_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ngfc_pkg::job_t push_job,
  input  wire logic           pop,
  output logic                nonempty,
  output logic                full,
  output ngfc_pkg::job_t      head
);
  ngfc_pkg::job_t slot_r [2];
  logic rd_r, wr_r;
  logic [1:0] cnt_r;

  assign nonempty = (cnt_r != 2'd0);
  assign full     = (cnt_r == 2'd2);
  assign head     = slot_r[rd_r];

  // Hold jobs, advance pointers
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_job;
    if (!rst_n) begin
      rd_r <= 1'b0; wr_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

[dv/testbench.sv]
// Testbench for the n-gram frequency counter: random and directed byte streams
// checked against a gram table predictor.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
  localparam int SETTLE_CYCLES = 20;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  ngfc_pkg::in_item_t in_item;
  logic out_valid;
  ngfc_pkg::out_item_t out_item;
  logic psel, penable, pwrite;
  logic [0:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  int mismatch_count = 0;
  bit gaps_on = 1'b1;

  ngram_frequency_counter dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Gram table predictor with a queue of expected results
  class gram_scoreboard;
    logic [2:0] gram_len;
    logic [23:0] win_bytes;
    int win_fill;
    logic [31:0] keys [ngfc_pkg::TABLE_ENTRIES];
    logic [31:0] counts [ngfc_pkg::TABLE_ENTRIES];
    int used;
    ngfc_pkg::out_item_t pending_grams [$];

    function new();
      gram_len = 3'd1;
      win_bytes = '0;
      win_fill = 0;
      used = 0;
    endfunction

    // Predict the result of one accepted item
    function void note_item(ngfc_pkg::in_item_t it);
      int n;
      logic [31:0] wide, mask, gram, cnt;
      bit found, drop;
      ngfc_pkg::out_item_t res;
      if (it.kind == ngfc_pkg::KIND_CLEAR) begin
        used = 0;
        win_bytes = '0;
        win_fill = 0;
        return;
      end
      n = (gram_len < 1) ? 1 : (gram_len > 4) ? 4 : int'(gram_len);
      if (win_fill + 1 >= n) begin
        wide = {win_bytes, it.text_byte};
        mask = (n == 4) ? 32'hFFFF_FFFF : ((32'h1 << (8 * n)) - 32'h1);
        gram = wide & mask;
        found = 1'b0;
        drop = 1'b0;
        cnt = '0;
        for (int i = 0; i < used; i++) begin
          if (!found && keys[i] == gram) begin
            if (counts[i] != COUNT_MAX) counts[i]++;
            cnt = counts[i];
            found = 1'b1;
          end
        end
        if (!found) begin
          if (used < ngfc_pkg::TABLE_ENTRIES) begin
            keys[used] = gram;
            counts[used] = 32'd1;
            used++;
            cnt = 32'd1;
          end else begin
            drop = 1'b1;
          end
        end
        res.gram = gram;
        res.gram_count = cnt;
        res.dropped = drop;
        res.last_gram = it.end_of_text;
        pending_grams = {pending_grams, res};
      end
      // Advance or empty the window
      if (it.end_of_text) begin
        win_bytes = '0;
        win_fill = 0;
      end else begin
        win_bytes = {win_bytes[15:0], it.text_byte};
        if (win_fill < 3) win_fill++;
      end
    endfunction

    // Compare one result with the oldest expectation
    task check_result(ngfc_pkg::out_item_t got);
      ngfc_pkg::out_item_t want;
      if (pending_grams.size() == 0) begin
        report_mismatch($sformatf("unexpected result gram=%h", got.gram));
        return;
      end
      want = pending_grams.pop_front();
      if (got.gram !== want.gram)
        report_mismatch($sformatf("gram got %h want %h", got.gram, want.gram));
      if (got.gram_count !== want.gram_count)
        report_mismatch($sformatf("gram_count got %0d want %0d for gram %h",
                                  got.gram_count, want.gram_count, want.gram));
      if (got.dropped !== want.dropped)
        report_mismatch($sformatf("dropped got %b want %b for gram %h",
                                  got.dropped, want.dropped, want.gram));
      if (got.last_gram !== want.last_gram)
        report_mismatch($sformatf("last_gram got %b want %b for gram %h",
                                  got.last_gram, want.last_gram, want.gram));
    endtask
  endclass

  gram_scoreboard sb;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Check every result strobe
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  // Send one item, after a random gap when gaps are on, and hold it until accepted
  task automatic send_item(input logic kind, input logic [7:0] b, input logic eot);
    int gap;
    gap = gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    in_item.kind = kind;
    in_item.text_byte = b;
    in_item.end_of_text = eot;
    do @(posedge clk); while (busy);
    sb.note_item(in_item);
    @(negedge clk);
  endtask

  // Hold off until every expected result has come, then let the block settle
  task automatic drain();
    start = 1'b0;
    while (sb.pending_grams.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write ngram_length through the APB port
  task automatic write_length(input logic [2:0] len);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = ngfc_pkg::REG_NGRAM_LENGTH;
    pwdata = {$urandom_range(0, 1) ? 29'($urandom) : 29'd0, len};
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    sb.gram_len = len;
  endtask

  // Stimulus
  initial begin
    logic [7:0] b;
    logic [2:0] lens [10];
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Letters at reset length: byte extremes and a repeat
    send_item(ngfc_pkg::KIND_TEXT, 8'h00, 1'b0);
    send_item(ngfc_pkg::KIND_TEXT, 8'hFF, 1'b0);
    send_item(ngfc_pkg::KIND_TEXT, 8'h00, 1'b1);
    // Clear ignores its byte and end flag
    send_item(ngfc_pkg::KIND_CLEAR, 8'hA5, 1'b1);
    send_item(ngfc_pkg::KIND_TEXT, 8'h00, 1'b0);
    drain();
    // Tetragrams: incomplete gram with end flag gives nothing
    write_length(3'd4);
    send_item(ngfc_pkg::KIND_TEXT, 8'h41, 1'b0);
    send_item(ngfc_pkg::KIND_TEXT, 8'h42, 1'b1);
    send_item(ngfc_pkg::KIND_TEXT, 8'hFF, 1'b0);
    send_item(ngfc_pkg::KIND_TEXT, 8'h80, 1'b0);
    send_item(ngfc_pkg::KIND_TEXT, 8'h01, 1'b0);
    send_item(ngfc_pkg::KIND_TEXT, 8'h7F, 1'b0);
    send_item(ngfc_pkg::KIND_TEXT, 8'hFE, 1'b1);
    drain();
    // Length change in the middle of a text keeps the window
    write_length(3'd2);
    send_item(ngfc_pkg::KIND_TEXT, 8'h61, 1'b0);
    send_item(ngfc_pkg::KIND_TEXT, 8'h62, 1'b0);
    drain();
    write_length(3'd3);
    send_item(ngfc_pkg::KIND_TEXT, 8'h63, 1'b0);
    drain();
    // Out-of-range lengths act as 1 and 4
    write_length(3'd0);
    send_item(ngfc_pkg::KIND_TEXT, 8'h63, 1'b1);
    drain();
    write_length(3'd7);
    send_item(ngfc_pkg::KIND_TEXT, 8'h61, 1'b0);
    send_item(ngfc_pkg::KIND_TEXT, 8'h62, 1'b0);
    send_item(ngfc_pkg::KIND_TEXT, 8'h63, 1'b0);
    send_item(ngfc_pkg::KIND_TEXT, 8'h64, 1'b1);
    drain();

    // Fill the table with distinct sliding bigrams (odd byte steps), then overflow it
    write_length(3'd2);
    gaps_on = 1'b0;
    send_item(ngfc_pkg::KIND_CLEAR, 8'h00, 1'b0);
    for (int s = 1; s < 10; s += 2) begin
      for (int k = 0; k < 210; k++) begin
        send_item(ngfc_pkg::KIND_TEXT, 8'(k * s), 1'b0);
      end
    end
    gaps_on = 1'b1;
    send_item(ngfc_pkg::KIND_TEXT, 8'h07, 1'b0);
    send_item(ngfc_pkg::KIND_TEXT, 8'h00, 1'b1);
    send_item(ngfc_pkg::KIND_TEXT, 8'h00, 1'b0);
    send_item(ngfc_pkg::KIND_TEXT, 8'h05, 1'b0);
    send_item(ngfc_pkg::KIND_TEXT, 8'h12, 1'b1);
    drain();
    send_item(ngfc_pkg::KIND_CLEAR, 8'h00, 1'b0);

    // Random texts over a small alphabet, one length per phase
    lens = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd5, 3'd2, 3'd6, 3'd3, 3'd7};
    foreach (lens[p]) begin
      drain();
      write_length(lens[p]);
      gaps_on = (p % 3) != 1;
      for (int k = 0; k < 37; k++) begin
        if ($urandom_range(0, 99) < 3) begin
          send_item(ngfc_pkg::KIND_CLEAR, 8'($urandom), 1'($urandom));
        end else begin
          if ($urandom_range(0, 99) < 20) b = 8'($urandom);
          else b = 8'h61 + 8'($urandom_range(0, 3));
          send_item(ngfc_pkg::KIND_TEXT, b, $urandom_range(0, 99) < 12);
        end
      end
    end

    // Wait out the last results
    drain();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && sb.pending_grams.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Timeout
  initial begin
    #(200_000_000);
    $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire

[ngram_frequency_counter.f]
src/ngfc_pkg.sv
src/ngfc_front.sv
src/ngfc_back.sv
src/ngfc_queue.sv
src/ngram_frequency_counter.sv
dv/testbench.sv
